// ===== src/triangle_grid_height_interp_top_assert.svh =====
// assertion macros used by the height interpolation rtl
`ifndef TRIANGLE_GRID_HEIGHT_INTERP_TOP_ASSERT_SVH
`define TRIANGLE_GRID_HEIGHT_INTERP_TOP_ASSERT_SVH

// same-cycle implication, checked on clk outside reset
`define TGH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgh assertion failed");

// next-cycle implication, checked on clk outside reset
`define TGH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgh assertion failed");

`endif

// ===== src/tgh_pkg.sv =====
// types, widths and codes shared by the height interpolation block
package tgh_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int FRAC_BITS    = 8;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);

    localparam int HEIGHT_W  = 24;
    localparam int COORD_W   = 21;
    localparam int INDEX_W   = 12;
    localparam int SIZE_W    = 13;
    localparam int CFG_IDX_W = 2;

    // clamped coordinates are never negative
    localparam int POS_W  = COORD_W - 1;
    localparam int CELL_W = POS_W - FRAC_BITS;
    localparam int U_W    = FRAC_BITS + 1;
    localparam int DIFF_W = HEIGHT_W + 1;
    localparam int PROD_W = DIFF_W + U_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG    = 2'd2;

    localparam logic [SIZE_W-1:0] COLUMNS_RESET = 13'd64;
    localparam logic [SIZE_W-1:0] ROWS_RESET    = 13'd64;
    localparam logic              DIAG_RESET    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE,
        ST_RD00,
        ST_RD10,
        ST_RD01,
        ST_RD11,
        ST_LAST,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] z00;
        logic signed [HEIGHT_W-1:0] z10;
        logic signed [HEIGHT_W-1:0] z01;
        logic signed [HEIGHT_W-1:0] z11;
    } corner_t;

    typedef struct packed {
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
        logic                 rising;
    } frac_t;

endpackage

// ===== src/tgh_store.sv =====
// single-port vertex height memory with registered read data
module tgh_store
    import tgh_pkg::*;
(
    input  logic                       clk,
    input  logic                       we,
    input  logic                       re,
    input  logic [ADDR_W-1:0]          addr,
    input  logic signed [HEIGHT_W-1:0] wdata,
    output logic signed [HEIGHT_W-1:0] rdata
);

    logic signed [HEIGHT_W-1:0] mem [MAX_VERTICES];
    logic signed [HEIGHT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tgh_interp.sv =====
// triangle selection, weighted differences and floored sum
module tgh_interp
    import tgh_pkg::*;
(
    input  logic                       clk,
    input  logic                       mul_en,
    input  corner_t                    corner,
    input  frac_t                      frac,
    output logic signed [HEIGHT_W-1:0] result
);

    localparam logic [U_W-1:0] ONE_U = U_W'(1) << FRAC_BITS;

    logic [U_W-1:0]             fx_u;
    logic [U_W-1:0]             fy_u;
    logic [U_W-1:0]             inv_fx;
    logic [U_W-1:0]             inv_fy;
    logic [U_W-1:0]             u;
    logic [U_W-1:0]             v;
    logic signed [HEIGHT_W-1:0] a;
    logic signed [HEIGHT_W-1:0] b;
    logic signed [HEIGHT_W-1:0] c;
    logic signed [DIFF_W-1:0]   d1;
    logic signed [DIFF_W-1:0]   d2;
    logic signed [PROD_W-1:0]   p1_next;
    logic signed [PROD_W-1:0]   p2_next;
    logic signed [PROD_W-1:0]   p1_reg;
    logic signed [PROD_W-1:0]   p2_reg;
    logic signed [HEIGHT_W-1:0] a_reg;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    sum_shr;

    assign fx_u   = {1'b0, frac.fx};
    assign fy_u   = {1'b0, frac.fy};
    assign inv_fx = ONE_U - fx_u;
    assign inv_fy = ONE_U - fy_u;

    always_comb
    begin
        if (frac.rising)
        begin
            if (fy_u <= fx_u)
            begin
                a = corner.z00; b = corner.z10; c = corner.z11; u = fx_u;   v = fy_u;
            end
            else
            begin
                a = corner.z11; b = corner.z01; c = corner.z00; u = inv_fx; v = inv_fy;
            end
        end
        else
        begin
            // lower-left triangle when fx + fy stays within one cell
            if (fy_u <= inv_fx)
            begin
                a = corner.z10; b = corner.z00; c = corner.z01; u = inv_fx; v = fy_u;
            end
            else
            begin
                a = corner.z01; b = corner.z11; c = corner.z10; u = fx_u;   v = inv_fy;
            end
        end
    end

    assign d1      = DIFF_W'(b) - DIFF_W'(a);
    assign d2      = DIFF_W'(c) - DIFF_W'(b);
    assign p1_next = d1 * $signed({1'b0, u});
    assign p2_next = d2 * $signed({1'b0, v});

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            a_reg  <= a;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    // arithmetic shift gives the floor for negative sums
    assign sum     = (SUM_W'(a_reg) <<< FRAC_BITS) + SUM_W'(p1_reg) + SUM_W'(p2_reg);
    assign sum_shr = sum >>> FRAC_BITS;
    assign result  = sum_shr[HEIGHT_W-1:0];

endmodule

// ===== src/triangle_grid_height_interp_top.sv =====
// top level: config registers, corner read sequencer, output register
//
//  channel  direction  handshake            payload
//  in       to block   in_valid / in_stall  req_type vertex_index height_value
//                                           col_coord row_coord
//  out      from block out_valid/out_stall  interp_height
//  cfg      to block   cfg_valid/cfg_ready  cfg_index cfg_data
//
// a height write is taken in idle and the next item is taken right after
// a query raises out_valid after the row address multiply, four reads of the
// single-port store, the read-latency state and the multiply and sum stages,
// and the next item is taken once the sequencer is back in idle; a held result
// stalls the sequencer only when the next query finishes while it waits
// rst_n clears control state asynchronously; the store holds no reset value
module triangle_grid_height_interp_top
    import tgh_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [INDEX_W-1:0]          vertex_index,
    input  logic signed [HEIGHT_W-1:0]  height_value,
    input  logic signed [COORD_W-1:0]   col_coord,
    input  logic signed [COORD_W-1:0]   row_coord,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [HEIGHT_W-1:0]  interp_height,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [SIZE_W-1:0]           cfg_data
);

    function automatic logic [POS_W-1:0] clamp_pos(
        input logic signed [COORD_W-1:0] coord,
        input logic [SIZE_W-1:0]         size
    );
        logic [SIZE_W+FRAC_BITS-1:0] top;
        logic [SIZE_W+FRAC_BITS-1:0] pos;
        logic [POS_W-1:0]            res;
        top = {size - SIZE_W'(1), {FRAC_BITS{1'b0}}};
        pos = (SIZE_W+FRAC_BITS)'(coord[POS_W-1:0]);
        if (coord[COORD_W-1])
        begin
            res = '0;
        end
        else if (pos > top)
        begin
            res = top[POS_W-1:0];
        end
        else
        begin
            res = coord[POS_W-1:0];
        end
        return res;
    endfunction

    state_t                     state_reg;
    state_t                     state_next;
    logic [SIZE_W-1:0]          columns_reg;
    logic [SIZE_W-1:0]          rows_reg;
    logic                       diag_reg;
    logic [SIZE_W-1:0]          cols_eff;
    logic [SIZE_W-1:0]          rows_eff;
    logic [SIZE_W-1:0]          cols_reg;
    logic [SIZE_W-1:0]          cols_next;
    logic [POS_W-1:0]           x_reg;
    logic [POS_W-1:0]           x_next;
    logic [POS_W-1:0]           y_reg;
    logic [POS_W-1:0]           y_next;
    logic                       rising_reg;
    logic                       rising_next;
    logic [ADDR_W-1:0]          base_reg;
    logic [ADDR_W-1:0]          base_next;
    logic [CELL_W+SIZE_W-1:0]   row_prod;
    corner_t                    corner_reg;
    corner_t                    corner_next;
    frac_t                      frac;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [HEIGHT_W-1:0] interp_height_reg;
    logic signed [HEIGHT_W-1:0] interp_height_next;
    logic signed [HEIGHT_W-1:0] interp_result;

    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [CELL_W-1:0]    ca;
    logic [CELL_W-1:0]    ra;
    logic [ADDR_W-1:0]    col_a;
    logic [ADDR_W-1:0]    col_b;
    logic [ADDR_W-1:0]    base_b;
    logic [ADDR_W-1:0]    addr00;
    logic [ADDR_W-1:0]    addr10;
    logic [ADDR_W-1:0]    addr01;
    logic [ADDR_W-1:0]    addr11;

    logic                       in_take;
    logic                       wr_in_range;
    logic                       mem_we;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_addr;
    logic signed [HEIGHT_W-1:0] mem_rdata;
    logic                       mul_en;
    logic                       out_load;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
            diag_reg    <= DIAG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COLUMNS: columns_reg <= cfg_data;
                CFG_ROWS:    rows_reg    <= cfg_data;
                CFG_DIAG:    diag_reg    <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // a zero grid size acts as one
    assign cols_eff = (columns_reg == '0) ? SIZE_W'(1) : columns_reg;
    assign rows_eff = (rows_reg == '0) ? SIZE_W'(1) : rows_reg;

    assign in_take     = in_valid && !in_stall;
    assign wr_in_range = (32'(vertex_index) < MAX_VERTICES);

    // cell split of the clamped coordinates
    assign fx  = x_reg[FRAC_BITS-1:0];
    assign fy  = y_reg[FRAC_BITS-1:0];
    assign ca  = x_reg[POS_W-1:FRAC_BITS];
    assign ra  = y_reg[POS_W-1:FRAC_BITS];

    assign row_prod = CELL_W'(ra) * cols_reg;

    // addresses wrap modulo the store depth; next row is one row stride on
    assign col_a  = ADDR_W'(ca);
    assign col_b  = col_a + ((fx != '0) ? ADDR_W'(1) : ADDR_W'(0));
    assign base_b = base_reg + ((fy != '0) ? cols_reg[ADDR_W-1:0] : ADDR_W'(0));
    assign addr00 = base_reg + col_a;
    assign addr10 = base_reg + col_b;
    assign addr01 = base_b + col_a;
    assign addr11 = base_b + col_b;

    assign frac.fx     = fx;
    assign frac.fy     = fy;
    assign frac.rising = rising_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && req_type)
                begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE: state_next = ST_RD00;
            ST_RD00: state_next = ST_RD10;
            ST_RD10: state_next = ST_RD01;
            ST_RD01: state_next = ST_RD11;
            ST_RD11: state_next = ST_LAST;
            ST_LAST: state_next = ST_MUL;
            ST_MUL:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall    = 1'b1;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = addr00;
        mul_en      = 1'b0;
        out_load    = 1'b0;
        cols_next   = cols_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        rising_next = rising_reg;
        base_next   = base_reg;
        corner_next = corner_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                mem_addr = vertex_index[ADDR_W-1:0];
                mem_we   = in_valid && !req_type && wr_in_range;
                if (in_valid && req_type)
                begin
                    cols_next   = cols_eff;
                    x_next      = clamp_pos(col_coord, cols_eff);
                    y_next      = clamp_pos(row_coord, rows_eff);
                    rising_next = diag_reg;
                end
            end
            ST_BASE:
            begin
                base_next = row_prod[ADDR_W-1:0];
            end
            ST_RD00:
            begin
                mem_re   = 1'b1;
                mem_addr = addr00;
            end
            ST_RD10:
            begin
                mem_re          = 1'b1;
                mem_addr        = addr10;
                corner_next.z00 = mem_rdata;
            end
            ST_RD01:
            begin
                mem_re          = 1'b1;
                mem_addr        = addr01;
                corner_next.z10 = mem_rdata;
            end
            ST_RD11:
            begin
                mem_re          = 1'b1;
                mem_addr        = addr11;
                corner_next.z01 = mem_rdata;
            end
            ST_LAST:
            begin
                corner_next.z11 = mem_rdata;
            end
            ST_MUL:
            begin
                mul_en = 1'b1;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cols_reg   <= cols_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        rising_reg <= rising_next;
        base_reg   <= base_next;
        corner_reg <= corner_next;
    end

    // output register
    always_comb
    begin
        out_valid_next     = out_valid_reg;
        interp_height_next = interp_height_reg;
        if (out_load)
        begin
            out_valid_next     = 1'b1;
            interp_height_next = interp_result;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        interp_height_reg <= interp_height_next;
    end

    assign out_valid     = out_valid_reg;
    assign interp_height = interp_height_reg;

    tgh_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (height_value),
        .rdata (mem_rdata)
    );

    tgh_interp u_interp (
        .clk    (clk),
        .mul_en (mul_en),
        .corner (corner_reg),
        .frac   (frac),
        .result (interp_result)
    );

`include "triangle_grid_height_interp_top_assert.svh"

    `TGH_ASSERT_NEXT(a_query_starts, in_take && req_type, state_reg == ST_BASE)
    `TGH_ASSERT_NOW(a_write_only_idle, mem_we, state_reg == ST_IDLE && in_take)
    `TGH_ASSERT_NOW(a_single_port, 1'b1, !(mem_we && mem_re))
    `TGH_ASSERT_NEXT(a_result_loaded, out_load, out_valid_reg && state_reg == ST_IDLE)

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the triangulated grid height interpolator
module testbench;
    import tgh_pkg::*;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = {1'b1, {(HEIGHT_W-1){1'b0}}};
    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = {1'b0, {(HEIGHT_W-1){1'b1}}};
    localparam longint COORD_MIN = -(longint'(1) <<< (COORD_W-1));
    localparam longint COORD_MAX = (longint'(1) <<< (COORD_W-1)) - 1;
    localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;

    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_LIMIT    = 4000;
    localparam int ITEM_TARGET   = 1050;

    typedef struct {
        logic                       kind;
        logic [INDEX_W-1:0]         index;
        logic signed [HEIGHT_W-1:0] height;
        logic signed [COORD_W-1:0]  col;
        logic signed [COORD_W-1:0]  row;
    } grid_req_t;

    typedef struct {
        logic [INDEX_W-1:0] a00;
        logic [INDEX_W-1:0] a10;
        logic [INDEX_W-1:0] a01;
        logic [INDEX_W-1:0] a11;
        longint             fx;
        longint             fy;
    } cell_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       req_type = 1'b0;
    logic [INDEX_W-1:0]         vertex_index = '0;
    logic signed [HEIGHT_W-1:0] height_value = '0;
    logic signed [COORD_W-1:0]  col_coord = '0;
    logic signed [COORD_W-1:0]  row_coord = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [HEIGHT_W-1:0] interp_height;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [SIZE_W-1:0]          cfg_data = '0;

    // predictor state
    logic signed [HEIGHT_W-1:0] height_mem [MAX_VERTICES];
    bit                         vertex_set [MAX_VERTICES];
    logic [SIZE_W-1:0]          cfg_cols = COLUMNS_RESET;
    logic [SIZE_W-1:0]          cfg_rows = ROWS_RESET;
    logic                       cfg_diag = DIAG_RESET;

    logic signed [HEIGHT_W-1:0] heights_due [$];
    int                         mismatches = 0;
    int                         idle_cycles = 0;
    int                         stall_left = 0;
    int                         items_sent = 0;
    bit                         no_idle = 1'b0;

    triangle_grid_height_interp_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .vertex_index (vertex_index),
        .height_value (height_value),
        .col_coord    (col_coord),
        .row_coord    (row_coord),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .interp_height(interp_height),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint clamp_pos(logic signed [COORD_W-1:0] coord, longint size);
        longint v;
        v = coord;
        if (v < 0)
            return 0;
        if (v > (size - 1) * FRAC_ONE)
            return (size - 1) * FRAC_ONE;
        return v;
    endfunction

    function automatic cell_t locate_cell(logic signed [COORD_W-1:0] col,
                                          logic signed [COORD_W-1:0] row);
        cell_t  c;
        longint cols, rows, x, y, ca, cb, ra, rb;
        // a zero size behaves as a single vertex
        cols = (cfg_cols == 0) ? 1 : cfg_cols;
        rows = (cfg_rows == 0) ? 1 : cfg_rows;
        x = clamp_pos(col, cols);
        y = clamp_pos(row, rows);
        ca = x / FRAC_ONE;
        c.fx = x % FRAC_ONE;
        cb = (c.fx != 0) ? ca + 1 : ca;
        ra = y / FRAC_ONE;
        c.fy = y % FRAC_ONE;
        rb = (c.fy != 0) ? ra + 1 : ra;
        // corner addresses wrap around the store
        c.a00 = INDEX_W'((ra * cols + ca) % MAX_VERTICES);
        c.a10 = INDEX_W'((ra * cols + cb) % MAX_VERTICES);
        c.a01 = INDEX_W'((rb * cols + ca) % MAX_VERTICES);
        c.a11 = INDEX_W'((rb * cols + cb) % MAX_VERTICES);
        return c;
    endfunction

    function automatic longint plane(longint p, longint q, longint w, longint u, longint v);
        longint s;
        s = p * FRAC_ONE + (q - p) * u + (w - q) * v;
        return s >>> FRAC_BITS;
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] predict_height(cell_t c);
        longint z00, z10, z01, z11, r;
        z00 = height_mem[c.a00];
        z10 = height_mem[c.a10];
        z01 = height_mem[c.a01];
        z11 = height_mem[c.a11];
        if (cfg_diag)
        begin
            if (c.fy <= c.fx)
                r = plane(z00, z10, z11, c.fx, c.fy);
            else
                r = plane(z11, z01, z00, FRAC_ONE - c.fx, FRAC_ONE - c.fy);
        end
        else
        begin
            if (c.fy <= FRAC_ONE - c.fx)
                r = plane(z10, z00, z01, FRAC_ONE - c.fx, c.fy);
            else
                r = plane(z01, z11, z10, c.fx, FRAC_ONE - c.fy);
        end
        return r[HEIGHT_W-1:0];
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] random_height();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return HEIGHT_MIN;
        if (pick == 1)
            return HEIGHT_MAX;
        return HEIGHT_W'($urandom());
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(longint size);
        longint top, v;
        int     pick;
        top = (size - 1) * FRAC_ONE;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            v = $urandom_range(top, 0);
        else if (pick < 70)
            v = longint'($urandom_range(size - 1, 0)) * FRAC_ONE;
        else if (pick < 80)
        begin
            v = $urandom_range(1, 600);
            v = (pick < 75) ? -v : top + v;
            if (v > COORD_MAX)
                v = COORD_MAX;
        end
        else
            v = $urandom();
        return v[COORD_W-1:0];
    endfunction

    task automatic report_mismatch(string what, logic signed [HEIGHT_W-1:0] got,
                                   logic signed [HEIGHT_W-1:0] want);
        $display("mismatch at %0t: %s, interp_height %0d, expected %0d", $realtime, what,
                 got, want);
        mismatches++;
    endtask

    // drives one transaction; valid stays high after acceptance unless a gap follows
    task automatic send_item(grid_req_t req);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req.kind;
        vertex_index <= req.index;
        height_value <= req.height;
        col_coord <= req.col;
        row_coord <= req.row;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (req.kind == REQ_WRITE)
        begin
            height_mem[req.index] = req.height;
            vertex_set[req.index] = 1'b1;
        end
        else
            heights_due.push_back(predict_height(locate_cell(req.col, req.row)));
    endtask

    task automatic send_write(logic [INDEX_W-1:0] idx, logic signed [HEIGHT_W-1:0] h);
        grid_req_t req;
        req.kind = REQ_WRITE;
        req.index = idx;
        req.height = h;
        req.col = COORD_W'($urandom());
        req.row = COORD_W'($urandom());
        send_item(req);
    endtask

    task automatic fill_vertex(logic [INDEX_W-1:0] idx);
        if (!vertex_set[idx])
            send_write(idx, random_height());
    endtask

    // corners never written get a height first, so no undefined entry is read
    task automatic send_query(logic signed [COORD_W-1:0] col, logic signed [COORD_W-1:0] row);
        cell_t     c;
        grid_req_t req;
        c = locate_cell(col, row);
        fill_vertex(c.a00);
        fill_vertex(c.a10);
        fill_vertex(c.a01);
        fill_vertex(c.a11);
        req.kind = REQ_QUERY;
        req.index = INDEX_W'($urandom());
        req.height = HEIGHT_W'($urandom());
        req.col = col;
        req.row = row;
        send_item(req);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (heights_due.size() != 0)
            @(posedge clk);
        // a height write in flight produces no result
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_COLUMNS: cfg_cols = value;
            CFG_ROWS:    cfg_rows = value;
            CFG_DIAG:    cfg_diag = value[0];
            default:     ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_grid(logic [SIZE_W-1:0] cols, logic [SIZE_W-1:0] rows, logic diag);
        drain();
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_DIAG, SIZE_W'(diag));
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return SIZE_W'(0);
            1:       return SIZE_W'(1);
            2:       return SIZE_W'(MAX_VERTICES);
            3, 4:    return SIZE_W'($urandom_range(MAX_VERTICES, 1));
            default: return SIZE_W'($urandom_range(40, 2));
        endcase
    endfunction

    task automatic random_item();
        longint cols, rows, span;
        int     pick;
        cols = (cfg_cols == 0) ? 1 : cfg_cols;
        rows = (cfg_rows == 0) ? 1 : cfg_rows;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            span = cols * rows;
            if (span > MAX_VERTICES)
                span = MAX_VERTICES;
            if (pick < 12)
                send_write(INDEX_W'($urandom_range(span - 1, 0)), random_height());
            else
                send_write(INDEX_W'($urandom()), random_height());
        end
        else
            send_query(pick_coord(cols), pick_coord(rows));
    endtask

    // reset grid, extreme heights and coordinates, points on grid lines
    task automatic test_corner_heights();
        send_write(0, HEIGHT_MIN);
        send_write(1, HEIGHT_MAX);
        send_write(64, 0);
        send_write(65, -1);
        send_write(MAX_VERTICES - 1, HEIGHT_MAX);
        send_query(0, 0);
        send_query(COORD_MIN, COORD_MIN);
        send_query(COORD_MAX, COORD_MAX);
        send_query(128, 64);
        send_query(64, 200);
        send_query(256, 128);
        send_query(100, 0);
    endtask

    // both triangles of a cell under each diagonal
    task automatic test_diagonal_split();
        set_grid(64, 64, 1'b0);
        send_query(128, 64);
        send_query(200, 200);
        send_query(128, 128);
        set_grid(64, 64, 1'b1);
        send_query(255, 0);
        send_query(1, 255);
    endtask

    // zero sizes, single row and column, full size with wrapping addresses
    task automatic test_grid_extremes();
        set_grid(0, 0, 1'b1);
        send_query(COORD_MAX, 300);
        set_grid(1, MAX_VERTICES, 1'b0);
        repeat (2) send_query(pick_coord(1), pick_coord(MAX_VERTICES));
        set_grid(MAX_VERTICES, 1, 1'b1);
        repeat (2) send_query(pick_coord(MAX_VERTICES), pick_coord(1));
        set_grid(MAX_VERTICES, MAX_VERTICES, 1'b0);
        send_query(COORD_MAX, COORD_MAX);
        send_query(pick_coord(MAX_VERTICES), pick_coord(MAX_VERTICES));
    endtask

    // each phase runs until its share of the total item count has been sent
    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++)
        begin
            set_grid(pick_size(), pick_size(), 1'($urandom_range(0, 1)));
            no_idle = (phase == 3);
            while (items_sent < ITEM_TARGET * (phase + 1) / 6)
                random_item();
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (heights_due.size() == 0)
                report_mismatch("result with nothing pending", interp_height, '0);
            else if (interp_height !== heights_due[0])
                report_mismatch("wrong height", interp_height, heights_due.pop_front());
            else
                void'(heights_due.pop_front());
        end
    end

    // ends the run when no transaction moves on any channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("triangle_grid_height_interp_top verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_heights();
        test_diagonal_split();
        test_grid_extremes();
        test_random_traffic();
        drain();
        if (mismatches == 0)
            $display("triangle_grid_height_interp_top verification clean");
        else
            $display("triangle_grid_height_interp_top verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/tgh_pkg.sv
src/tgh_store.sv
src/tgh_interp.sv
src/triangle_grid_height_interp_top.sv
sim/testbench.sv
